// ----- sv/assert_macros.svh -----
// assertion macros used by the scheduler top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define FTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// implication, consequent checked in the same cycle
`define FTS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- sv/fts_pkg.sv -----
// shared types, constants and helpers of the thread scheduler
package fts_pkg;

   localparam int NUM_THREADS = 16;
   localparam int ID_W        = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int CNT_W       = $clog2(NUM_THREADS + 1);
   localparam int FIELD_W     = 4;
   localparam int WIDE_W      = 8;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_YIELD  = 2'd1,
      OP_SCHED  = 2'd2,
      OP_EXIT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_FULL       = 2'd1,
      STS_BAD_TARGET = 2'd2,
      STS_NONE_LEFT  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_SCAN,
      S_MARK,
      S_BUBBLE,
      S_PUSH,
      S_SWITCH,
      S_DONE
   } state_type;

   // broadcast to every queue cell
   typedef struct packed {
      logic            mark;
      logic            mark_head;
      logic            shift;
      logic            push;
      logic [ID_W-1:0] key;
      logic [ID_W-1:0] push_id;
   } cell_ctrl_type;

   // where a cell stands relative to the queue fill
   typedef struct packed {
      logic in_use;
      logic is_tail;
      logic is_slot;
      logic at_head;
   } cell_pos_type;

   function automatic logic [ID_W-1:0] id_inc(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] res;
      if (id == ID_W'(NUM_THREADS - 1)) begin
         res = '0;
      end else begin
         res = id + ID_W'(1);
      end
      return res;
   endfunction

   // low bits of an id for a result field
   function automatic logic [FIELD_W-1:0] to_field(input logic [ID_W-1:0] id);
      logic [ID_W+FIELD_W-1:0] w;
      w = {{FIELD_W{1'b0}}, id};
      return w[FIELD_W-1:0];
   endfunction

endpackage

// ----- sv/fts_cell.sv -----
// one ready queue cell: holds an id and the travelling hole bit
module fts_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  fts_pkg::cell_ctrl_type ctrl,
   input  fts_pkg::cell_pos_type  pos,
   input  logic [fts_pkg::ID_W-1:0] right_id,
   input  logic                  left_hole,
   output logic [fts_pkg::ID_W-1:0] id,
   output logic                  hole
);

   logic [fts_pkg::ID_W-1:0] id_ff, id_in;
   logic                     hole_ff, hole_in;

   always_comb begin
      id_in   = id_ff;
      hole_in = hole_ff;
      if (ctrl.mark) begin
         hole_in = pos.in_use && (ctrl.mark_head ? pos.at_head : (id_ff == ctrl.key));
      end else if (ctrl.shift) begin
         // hole moves one cell right, the right neighbor's id fills it
         hole_in = left_hole;
         if (hole_ff && !pos.is_tail) begin
            id_in = right_id;
         end
      end else if (ctrl.push && pos.is_slot) begin
         id_in = ctrl.push_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hole_ff <= 1'b0;
      end else begin
         hole_ff <= hole_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id   = id_ff;
   assign hole = hole_ff;

endmodule

// ----- sv/fts_queue.sv -----
// ready queue as a row of cells, head at cell zero
module fts_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  fts_pkg::cell_ctrl_type     ctrl,
   input  logic [fts_pkg::CNT_W-1:0] qcnt,
   output logic [fts_pkg::ID_W-1:0]  head_id,
   output logic                      tail_hole
);

   localparam int N = fts_pkg::NUM_THREADS;

   logic [fts_pkg::ID_W-1:0] id_vec [N];
   logic [N-1:0]             hole_vec;
   logic [N-1:0]             tail_vec;

   for (genvar i = 0; i < N; i++) begin : g_cell
      fts_pkg::cell_pos_type    pos;
      logic [fts_pkg::ID_W-1:0] right_id;
      logic                     left_hole;

      assign pos.in_use  = fts_pkg::CNT_W'(i) < qcnt;
      assign pos.is_tail = qcnt == fts_pkg::CNT_W'(i + 1);
      assign pos.is_slot = qcnt == fts_pkg::CNT_W'(i);
      assign pos.at_head = 1'(i == 0);
      assign tail_vec[i] = pos.is_tail;

      if (i < N - 1) begin : g_right
         assign right_id = id_vec[i+1];
      end else begin : g_last
         assign right_id = '0;
      end

      if (i > 0) begin : g_left
         assign left_hole = hole_vec[i-1] & ~tail_vec[i-1];
      end else begin : g_first
         assign left_hole = 1'b0;
      end

      fts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .pos       (pos),
         .right_id  (right_id),
         .left_hole (left_hole),
         .id        (id_vec[i]),
         .hole      (hole_vec[i])
      );
   end

   assign head_id   = id_vec[0];
   assign tail_hole = |(hole_vec & tail_vec);

endmodule

// ----- sv/fifo_thread_scheduler.sv -----
// thread scheduler top level: thread table, ready queue row and sequencer
// work: create runs the free slot scan that checks one slot a cycle; yield, sched
//   and exit wait for the hole travelling one queue cell a cycle
// throughput: one item at a time; the next item is taken while a result beat waits
// reset: synchronous; thread 0 live and running, queue empty, no clearing pass
`include "assert_macros.svh"

module fifo_thread_scheduler (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_target,
   input  logic [31:0] req_start_addr,
   input  logic [31:0] req_start_arg,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_new_id,
   output logic [3:0]  rsp_running,
   output logic [3:0]  rsp_resumed_by,
   output logic        rsp_resumed_by_valid,
   output logic        rsp_first_run,
   output logic [31:0] rsp_run_addr,
   output logic [31:0] rsp_run_arg
);

   localparam int N    = fts_pkg::NUM_THREADS;
   localparam int ID_W = fts_pkg::ID_W;
   localparam int CW   = fts_pkg::CNT_W;

   // sequencer state
   fts_pkg::state_type state_ff, state_in;

   // captured request beat
   fts_pkg::op_type op_ff, op_in;
   logic [3:0]      target_ff, target_in;
   logic [31:0]     addr_ff, addr_in;
   logic [31:0]     arg_ff, arg_in;

   // thread table flags and scheduler registers
   logic [N-1:0]    live_ff, live_in;
   logic [N-1:0]    started_ff, started_in;
   logic [ID_W-1:0] current_ff, current_in;
   logic [ID_W-1:0] last_ff, last_in;
   logic [CW-1:0]   live_cnt_ff, live_cnt_in;
   logic [CW-1:0]   qcnt_ff, qcnt_in;
   logic            halted_ff, halted_in;

   // per item work registers
   logic [ID_W-1:0] scan_ff, scan_in;
   logic [ID_W-1:0] next_ff, next_in;
   logic            push_ff, push_in;
   logic            mark_head_ff, mark_head_in;
   fts_pkg::status_type status_ff, status_in;
   logic [ID_W-1:0] new_id_ff, new_id_in;
   logic [ID_W-1:0] res_by_ff, res_by_in;
   logic            res_by_v_ff, res_by_v_in;
   logic            first_ff, first_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [3:0]      rsp_new_id_ff, rsp_new_id_in;
   logic [3:0]      rsp_running_ff, rsp_running_in;
   logic [3:0]      rsp_res_by_ff, rsp_res_by_in;
   logic            rsp_res_by_v_ff, rsp_res_by_v_in;
   logic            rsp_first_ff, rsp_first_in;
   logic [31:0]     rsp_addr_ff, rsp_addr_in;
   logic [31:0]     rsp_arg_ff, rsp_arg_in;

   // entry address and argument stores, one write and one read port each
   logic [31:0]     addr_mem [N];
   logic [31:0]     arg_mem  [N];
   logic [31:0]     mem_addr_rd_ff;
   logic [31:0]     mem_arg_rd_ff;
   logic            alloc_we;

   // queue row interface
   fts_pkg::cell_ctrl_type qctrl;
   logic [ID_W-1:0] head_id;
   logic            tail_hole;

   // target range check in a width that holds thread counts up to 255
   logic [fts_pkg::WIDE_W-1:0] tgt_wide;
   logic [ID_W-1:0]            tgt_id;
   logic                       tgt_bad;
   logic                       accept;
   logic                       rsp_free;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign tgt_wide = fts_pkg::WIDE_W'(target_ff);
   assign tgt_id   = tgt_wide[ID_W-1:0];
   assign tgt_bad  = (tgt_wide >= fts_pkg::WIDE_W'(N)) || !live_ff[tgt_id];
   assign alloc_we = (state_ff == fts_pkg::S_SCAN) && !live_ff[scan_ff];

   fts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (qctrl),
      .qcnt      (qcnt_ff),
      .head_id   (head_id),
      .tail_hole (tail_hole)
   );

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      target_in       = target_ff;
      addr_in         = addr_ff;
      arg_in          = arg_ff;
      live_in         = live_ff;
      started_in      = started_ff;
      current_in      = current_ff;
      last_in         = last_ff;
      live_cnt_in     = live_cnt_ff;
      qcnt_in         = qcnt_ff;
      halted_in       = halted_ff;
      scan_in         = scan_ff;
      next_in         = next_ff;
      push_in         = push_ff;
      mark_head_in    = mark_head_ff;
      status_in       = status_ff;
      new_id_in       = new_id_ff;
      res_by_in       = res_by_ff;
      res_by_v_in     = res_by_v_ff;
      first_in        = first_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_new_id_in   = rsp_new_id_ff;
      rsp_running_in  = rsp_running_ff;
      rsp_res_by_in   = rsp_res_by_ff;
      rsp_res_by_v_in = rsp_res_by_v_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_arg_in      = rsp_arg_ff;
      // a waiting beat leaves when the far side takes it
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      qctrl.mark      = 1'b0;
      qctrl.mark_head = mark_head_ff;
      qctrl.shift     = 1'b0;
      qctrl.push      = 1'b0;
      qctrl.key       = next_ff;
      qctrl.push_id   = current_ff;

      req_stall = (state_ff != fts_pkg::S_IDLE);

      unique case (state_ff)
         fts_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = fts_pkg::op_type'(req_op);
               target_in = req_target;
               addr_in   = req_start_addr;
               arg_in    = req_start_arg;
               state_in  = fts_pkg::S_EVAL;
            end
         end

         fts_pkg::S_EVAL: begin
            status_in   = fts_pkg::STS_OK;
            new_id_in   = '0;
            res_by_in   = '0;
            res_by_v_in = 1'b0;
            first_in    = 1'b0;
            state_in    = fts_pkg::S_DONE;
            if (halted_ff) begin
               // after the last exit everything answers none left
               status_in = fts_pkg::STS_NONE_LEFT;
            end else begin
               unique case (op_ff)
                  fts_pkg::OP_CREATE: begin
                     if (live_cnt_ff >= CW'(N)) begin
                        status_in = fts_pkg::STS_FULL;
                     end else begin
                        // circular search starts right after the last slot handed out
                        scan_in  = fts_pkg::id_inc(last_ff);
                        state_in = fts_pkg::S_SCAN;
                     end
                  end
                  fts_pkg::OP_YIELD: begin
                     if (tgt_bad) begin
                        status_in = fts_pkg::STS_BAD_TARGET;
                     end else begin
                        res_by_in   = current_ff;
                        res_by_v_in = 1'b1;
                        // yield to self leaves everything as it is
                        if (tgt_id != current_ff) begin
                           next_in      = tgt_id;
                           push_in      = 1'b1;
                           mark_head_in = 1'b0;
                           state_in     = fts_pkg::S_MARK;
                        end
                     end
                  end
                  fts_pkg::OP_SCHED: begin
                     // empty queue: the running thread simply keeps going
                     if (qcnt_ff != '0) begin
                        next_in      = head_id;
                        push_in      = 1'b1;
                        mark_head_in = 1'b1;
                        state_in     = fts_pkg::S_MARK;
                     end
                  end
                  fts_pkg::OP_EXIT: begin
                     live_in[current_ff] = 1'b0;
                     live_cnt_in         = live_cnt_ff - CW'(1);
                     if (qcnt_ff == '0) begin
                        halted_in = 1'b1;
                        status_in = fts_pkg::STS_NONE_LEFT;
                     end else begin
                        next_in      = head_id;
                        push_in      = 1'b0;
                        mark_head_in = 1'b1;
                        state_in     = fts_pkg::S_MARK;
                     end
                  end
                  default: begin
                     status_in = fts_pkg::STS_OK;
                  end
               endcase
            end
         end

         fts_pkg::S_SCAN: begin
            if (!live_ff[scan_ff]) begin
               live_in[scan_ff]    = 1'b1;
               started_in[scan_ff] = 1'b0;
               last_in             = scan_ff;
               live_cnt_in         = live_cnt_ff + CW'(1);
               new_id_in           = scan_ff;
               // new thread goes to the back of the queue
               qctrl.push          = 1'b1;
               qctrl.push_id       = scan_ff;
               qcnt_in             = qcnt_ff + CW'(1);
               state_in            = fts_pkg::S_DONE;
            end else begin
               scan_in = fts_pkg::id_inc(scan_ff);
            end
         end

         fts_pkg::S_MARK: begin
            // open a hole at the leaving thread's cell
            qctrl.mark = 1'b1;
            state_in   = fts_pkg::S_BUBBLE;
         end

         fts_pkg::S_BUBBLE: begin
            // hole walks to the tail, closing the gap one cell a cycle
            qctrl.shift = 1'b1;
            if (tail_hole) begin
               qcnt_in  = qcnt_ff - CW'(1);
               state_in = fts_pkg::S_PUSH;
            end
         end

         fts_pkg::S_PUSH: begin
            // caller goes to the back, except on exit
            if (push_ff) begin
               qctrl.push = 1'b1;
               qcnt_in    = qcnt_ff + CW'(1);
            end
            state_in = fts_pkg::S_SWITCH;
         end

         fts_pkg::S_SWITCH: begin
            current_in = next_ff;
            if (!started_ff[next_ff]) begin
               started_in[next_ff] = 1'b1;
               first_in            = 1'b1;
            end
            state_in = fts_pkg::S_DONE;
         end

         fts_pkg::S_DONE: begin
            // stored entry values are read at next_ff, settled since eval
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_new_id_in   = fts_pkg::to_field(new_id_ff);
               rsp_running_in  = (status_ff == fts_pkg::STS_NONE_LEFT) ?
                                 4'd0 : fts_pkg::to_field(current_ff);
               rsp_res_by_in   = fts_pkg::to_field(res_by_ff);
               rsp_res_by_v_in = res_by_v_ff;
               rsp_first_in    = first_ff;
               rsp_addr_in     = first_ff ? mem_addr_rd_ff : 32'd0;
               rsp_arg_in      = first_ff ? mem_arg_rd_ff : 32'd0;
               state_in        = fts_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fts_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fts_pkg::S_IDLE;
         live_ff      <= N'(1);
         started_ff   <= N'(1);
         current_ff   <= '0;
         last_ff      <= '0;
         live_cnt_ff  <= CW'(1);
         qcnt_ff      <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         started_ff   <= started_in;
         current_ff   <= current_in;
         last_ff      <= last_in;
         live_cnt_ff  <= live_cnt_in;
         qcnt_ff      <= qcnt_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      target_ff       <= target_in;
      addr_ff         <= addr_in;
      arg_ff          <= arg_in;
      scan_ff         <= scan_in;
      next_ff         <= next_in;
      push_ff         <= push_in;
      mark_head_ff    <= mark_head_in;
      status_ff       <= status_in;
      new_id_ff       <= new_id_in;
      res_by_ff       <= res_by_in;
      res_by_v_ff     <= res_by_v_in;
      first_ff        <= first_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_new_id_ff   <= rsp_new_id_in;
      rsp_running_ff  <= rsp_running_in;
      rsp_res_by_ff   <= rsp_res_by_in;
      rsp_res_by_v_ff <= rsp_res_by_v_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_addr_ff     <= rsp_addr_in;
      rsp_arg_ff      <= rsp_arg_in;
   end

   // entry stores: written on allocation, read registered at the next thread
   always_ff @(posedge clock) begin
      if (alloc_we) begin
         addr_mem[scan_ff] <= addr_ff;
         arg_mem[scan_ff]  <= arg_ff;
      end
      mem_addr_rd_ff <= addr_mem[next_ff];
      mem_arg_rd_ff  <= arg_mem[next_ff];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_new_id           = rsp_new_id_ff;
   assign rsp_running          = rsp_running_ff;
   assign rsp_resumed_by       = rsp_res_by_ff;
   assign rsp_resumed_by_valid = rsp_res_by_v_ff;
   assign rsp_first_run        = rsp_first_ff;
   assign rsp_run_addr         = rsp_addr_ff;
   assign rsp_run_arg          = rsp_arg_ff;

   // live count tracks the live flags
   `FTS_ASSERT(a_live_count, CW'($countones(live_ff)) == live_cnt_ff, "live count out of step")

   // between items every live thread but the running one sits in the queue
   `FTS_ASSERT_IMPL(a_queue_fill, (state_ff == fts_pkg::S_IDLE) && !halted_ff,
      qcnt_ff + CW'(1) == live_cnt_ff, "queue fill does not match live threads")

   // the running thread is live between items while not halted
   `FTS_ASSERT_IMPL(a_current_live, (state_ff == fts_pkg::S_IDLE) && !halted_ff,
      live_ff[current_ff], "running thread not live")

   // a result beat only appears out of the done step
   `FTS_ASSERT_IMPL(a_rsp_source, $rose(rsp_valid_ff),
      $past(state_ff == fts_pkg::S_DONE), "result beat without done step")

endmodule

// ----- bench/sched_table_check.sv -----
// checker for the thread scheduler: predicts each response beat from the request beats
module sched_table_check
   import fts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_target,
   input  logic [31:0] req_start_addr,
   input  logic [31:0] req_start_arg,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [3:0]  rsp_new_id,
   input  logic [3:0]  rsp_running,
   input  logic [3:0]  rsp_resumed_by,
   input  logic        rsp_resumed_by_valid,
   input  logic        rsp_first_run,
   input  logic [31:0] rsp_run_addr,
   input  logic [31:0] rsp_run_arg,
   output int unsigned results_due,
   output int unsigned mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] new_id;
      logic [FIELD_W-1:0] running;
      logic [FIELD_W-1:0] resumed_by;
      logic               resumed_by_valid;
      logic               first_run;
      logic [31:0]        run_addr;
      logic [31:0]        run_arg;
   } sched_result_type;

   // thread table and ready queue as the scheduler should hold them
   logic            live [NUM_THREADS];
   logic            started [NUM_THREADS];
   logic [31:0]     entry_addr [NUM_THREADS];
   logic [31:0]     entry_arg [NUM_THREADS];
   logic [ID_W-1:0] ready_ids [$];
   logic [ID_W-1:0] running_id;
   logic [ID_W-1:0] last_slot;
   int unsigned     live_total;
   logic            halted;

   sched_result_type due_results [$];
   int unsigned      mismatches;

   function automatic void resume_thread(input logic [ID_W-1:0] id,
                                         inout sched_result_type r);
      running_id = id;
      if (!started[id]) begin
         started[id] = 1'b1;
         r.first_run = 1'b1;
         r.run_addr  = entry_addr[id];
         r.run_arg   = entry_arg[id];
      end
   endfunction

   function automatic sched_result_type schedule_step(input op_type op,
                                                      input logic [3:0] tgt,
                                                      input logic [31:0] addr,
                                                      input logic [31:0] arg);
      sched_result_type r;
      logic [ID_W-1:0]  slot;
      logic [ID_W-1:0]  nxt;
      logic             found;
      int               pos;
      r        = '0;
      r.status = STS_OK;
      if (halted) begin
         r.status = STS_NONE_LEFT;
      end else begin
         case (op)
            OP_CREATE: begin
               found = 1'b0;
               slot  = last_slot;
               if (live_total < NUM_THREADS) begin
                  for (int i = 0; i < NUM_THREADS && !found; i++) begin
                     slot = (slot == ID_W'(NUM_THREADS - 1)) ? '0 : slot + 1'b1;
                     if (!live[slot]) found = 1'b1;
                  end
               end
               if (!found) begin
                  r.status = STS_FULL;
               end else begin
                  live[slot]       = 1'b1;
                  started[slot]    = 1'b0;
                  entry_addr[slot] = addr;
                  entry_arg[slot]  = arg;
                  last_slot        = slot;
                  live_total++;
                  if (ready_ids.size() < NUM_THREADS) ready_ids.push_back(slot);
                  r.new_id = FIELD_W'(slot);
               end
            end
            OP_YIELD: begin
               if (int'(tgt) >= NUM_THREADS || !live[tgt]) begin
                  r.status = STS_BAD_TARGET;
               end else begin
                  r.resumed_by       = FIELD_W'(running_id);
                  r.resumed_by_valid = 1'b1;
                  if (ID_W'(tgt) != running_id) begin
                     for (pos = 0; pos < ready_ids.size(); pos++) begin
                        if (ready_ids[pos] == ID_W'(tgt)) break;
                     end
                     if (pos < ready_ids.size()) ready_ids.delete(pos);
                     ready_ids.push_back(running_id);
                     resume_thread(ID_W'(tgt), r);
                  end
               end
            end
            OP_SCHED: begin
               if (ready_ids.size() > 0) begin
                  nxt = ready_ids.pop_front();
                  ready_ids.push_back(running_id);
                  resume_thread(nxt, r);
               end
            end
            default: begin
               live[running_id] = 1'b0;
               if (live_total > 0) live_total--;
               if (ready_ids.size() == 0) begin
                  halted   = 1'b1;
                  r.status = STS_NONE_LEFT;
               end else begin
                  nxt = ready_ids.pop_front();
                  resume_thread(nxt, r);
               end
            end
         endcase
      end
      r.running = (r.status == STS_NONE_LEFT) ? '0 : FIELD_W'(running_id);
      return r;
   endfunction

   function automatic string show(input sched_result_type r);
      return {$sformatf("status=%0d new_id=%0d running=%0d ",
                        r.status, r.new_id, r.running),
              $sformatf("resumed_by=%0d/%0b first=%0b addr=%h arg=%h",
                        r.resumed_by, r.resumed_by_valid, r.first_run,
                        r.run_addr, r.run_arg)};
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_THREADS; i++) begin
            live[i]       = (i == 0);
            started[i]    = (i == 0);
            entry_addr[i] = '0;
            entry_arg[i]  = '0;
         end
         ready_ids.delete();
         due_results.delete();
         running_id = '0;
         last_slot  = '0;
         live_total = 1;
         halted     = 1'b0;
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status           = status_type'(rsp_status);
            got.new_id           = rsp_new_id;
            got.running          = rsp_running;
            got.resumed_by       = rsp_resumed_by;
            got.resumed_by_valid = rsp_resumed_by_valid;
            got.first_run        = rsp_first_run;
            got.run_addr         = rsp_run_addr;
            got.run_arg          = rsp_run_arg;
            if (due_results.size() == 0) begin
               note_mismatch({"beat with nothing due: ", show(got)});
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  note_mismatch({"expected ", show(want), " got ", show(got)});
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_results.push_back(schedule_step(op_type'(req_op), req_target,
                                                req_start_addr, req_start_arg));
         end
      end
      results_due    <= due_results.size();
      mismatch_count <= mismatches;
   end

endmodule

// ----- bench/tb.sv -----
// testbench top for the thread scheduler: clock, reset, request stimulus and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fts_pkg::*;

   // quiet cycles allowed before the run is declared hung; well above the long hold-off
   localparam int WATCHDOG_LIMIT = 2000;
   // length of the long receiver hold-off that fills the block
   localparam int HOLD_CYCLES    = 300;
   // accept-to-result allowance, scaled by the thread count
   localparam int MAX_LATENCY    = NUM_THREADS + 4;
   localparam int BURST_ITEMS    = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op         = OP_SCHED;
   logic [3:0]  req_target     = '0;
   logic [31:0] req_start_addr = '0;
   logic [31:0] req_start_arg  = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_new_id;
   logic [3:0]  rsp_running;
   logic [3:0]  rsp_resumed_by;
   logic        rsp_resumed_by_valid;
   logic        rsp_first_run;
   logic [31:0] rsp_run_addr;
   logic [31:0] rsp_run_arg;

   int unsigned results_due;
   int unsigned mismatch_count;

   // idling knobs, changed per phase
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        squeeze_req = 1'b0;

   // live thread count as the stimulus sees it; zero once the last thread has exited
   int          alive = 1;
   logic        timed_out = 1'b0;

   fifo_thread_scheduler dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_target           (req_target),
      .req_start_addr       (req_start_addr),
      .req_start_arg        (req_start_arg),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_new_id           (rsp_new_id),
      .rsp_running          (rsp_running),
      .rsp_resumed_by       (rsp_resumed_by),
      .rsp_resumed_by_valid (rsp_resumed_by_valid),
      .rsp_first_run        (rsp_first_run),
      .rsp_run_addr         (rsp_run_addr),
      .rsp_run_arg          (rsp_run_arg)
   );

   sched_table_check u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_target           (req_target),
      .req_start_addr       (req_start_addr),
      .req_start_arg        (req_start_arg),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_new_id           (rsp_new_id),
      .rsp_running          (rsp_running),
      .rsp_resumed_by       (rsp_resumed_by),
      .rsp_resumed_by_valid (rsp_resumed_by_valid),
      .rsp_first_run        (rsp_first_run),
      .rsp_run_addr         (rsp_run_addr),
      .rsp_run_arg          (rsp_run_arg),
      .results_due          (results_due),
      .mismatch_count       (mismatch_count)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // response side: random stall, plus one long hold-off counted here when asked for
   int hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (squeeze_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // offer one request beat and hold it until the block takes it
   task automatic send_beat(input op_type op, input logic [3:0] tgt,
                            input logic [31:0] addr, input logic [31:0] arg);
      // random sender gaps in front of the beat
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_target     <= tgt;
      req_start_addr <= addr;
      req_start_arg  <= arg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // keep the live count in step so the last thread only exits at the end
      if (alive > 0) begin
         if (op == OP_CREATE && alive < NUM_THREADS) alive++;
         if (op == OP_EXIT) alive--;
      end
   endtask

   // random mix of all four ops; exit is held back while only one thread lives
   task automatic random_burst(input int count);
      int     roll;
      op_type op;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 25) op = OP_CREATE;
         else if (roll < 55) op = OP_YIELD;
         else if (roll < 75) op = OP_SCHED;
         else op = OP_EXIT;
         if (op == OP_EXIT && alive <= 1) op = OP_SCHED;
         send_beat(op, 4'($urandom_range(15)), $urandom, $urandom);
      end
   endtask

   initial begin
      fork
         begin
            repeat (2) @(posedge clock);
            reset <= 1'b0;

            // directed part
            // empty queue on schedule: thread 0 keeps running
            send_beat(OP_SCHED, 4'd0, 32'h0, 32'h0);
            // yield to self: nothing moves, caller reported
            send_beat(OP_YIELD, 4'd0, 32'h0, 32'h0);
            // yield to a slot that was never created
            send_beat(OP_YIELD, 4'd5, '1, '1);
            // fill the table, address and argument extremes first
            send_beat(OP_CREATE, 4'd0, 32'h0, 32'h0);
            send_beat(OP_CREATE, 4'd15, '1, '1);
            repeat (13) send_beat(OP_CREATE, 4'($urandom_range(15)), $urandom, $urandom);
            // table full
            send_beat(OP_CREATE, 4'd3, $urandom, $urandom);
            // first run of the highest slot, then a yield to self from it
            send_beat(OP_YIELD, 4'd15, 32'h0, 32'h0);
            send_beat(OP_YIELD, 4'd15, 32'h0, 32'h0);
            // schedule the queue head, which starts fresh
            send_beat(OP_SCHED, 4'd0, 32'h0, 32'h0);
            // exit the running thread, then reuse its slot by a wrapping scan
            send_beat(OP_EXIT, 4'd0, 32'h0, 32'h0);
            send_beat(OP_CREATE, 4'd9, $urandom, $urandom);

            // phase 0: no idling; one long hold-off on the response side while requests
            // keep coming, so the block backs up into its request side
            squeeze_req <= 1'b1;
            random_burst(BURST_ITEMS);
            // phase 1: sender gaps
            send_idle_pct = 60;
            random_burst(BURST_ITEMS);
            // phase 2: receiver stalls
            send_idle_pct = 0;
            recv_stall_pct <= 60;
            random_burst(BURST_ITEMS);
            // phase 3: both
            send_idle_pct = 26;
            recv_stall_pct <= 26;
            random_burst(BURST_ITEMS);

            // last thread exits, then every op is answered with no threads left
            while (alive > 0) send_beat(OP_EXIT, 4'($urandom_range(15)), $urandom, $urandom);
            send_beat(OP_CREATE, 4'($urandom_range(15)), $urandom, $urandom);
            send_beat(OP_YIELD, 4'd0, $urandom, $urandom);
            send_beat(OP_SCHED, 4'($urandom_range(15)), $urandom, $urandom);
            send_beat(OP_EXIT, 4'($urandom_range(15)), $urandom, $urandom);
            req_valid <= 1'b0;

            // the checker's count is registered and trails the last accept
            @(posedge clock);
            while (results_due != 0) @(posedge clock);
            repeat (2 * MAX_LATENCY) @(posedge clock);
         end
         begin
            // watchdog: cycles in which neither channel moves a beat
            int quiet;
            quiet = 0;
            while (quiet < WATCHDOG_LIMIT) begin
               @(posedge clock);
               if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
               else quiet++;
            end
            timed_out = 1'b1;
         end
      join_any
      if (timed_out) begin
         $display("FAIL");
      end else if (mismatch_count == 0 && results_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fts_pkg.sv
sv/fts_cell.sv
sv/fts_queue.sv
sv/fifo_thread_scheduler.sv
bench/sched_table_check.sv
bench/tb.sv
